FILE: rtl/atrp_pkg.sv
// Package for the AT response parser: ROM of response strings, parse states,
// event codes and controller/datapath command types. No dependencies.
package atrp_pkg;

    localparam int RESPONSE_COUNT = 18;
    localparam int IP_CHARS       = 16;
    localparam int QUIET_LIMIT    = 2;
    localparam int MAX_LEN        = 19;

    typedef enum logic [3:0] {
        PS_IDLE    = 4'd0,
        PS_MATCH   = 4'd1,
        PS_WAIT_NL = 4'd2,
        PS_STAIP   = 4'd5,
        PS_QUOTE   = 4'd6,
        PS_IP      = 4'd7,
        PS_IP_NL   = 4'd8,
        PS_IPD     = 4'd10,
        PS_LEN     = 4'd11,
        PS_PAYLOAD = 4'd12,
        PS_CONN    = 4'd13
    } t_pstate;

    localparam logic [2:0] EV_DONE    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_IP_CHAR = 3'd2;
    localparam logic [2:0] EV_IP_DONE = 3'd3;
    localparam logic [2:0] EV_IP_BAD  = 3'd4;
    localparam logic [2:0] EV_PROMPT  = 3'd5;

    typedef enum logic [2:0] {
        C_IDLE,
        C_EXEC,
        C_SCAN,
        C_OUT
    } t_cstate;

    // Command from controller to datapath.
    typedef struct packed {
        logic load;      // latch accepted item
        logic step;      // process byte in current parse state (no scan)
        logic scan_init; // start a ROM scan
        logic scan_next; // evaluate one ROM entry
        logic tick;      // apply a tick
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_scan; // current state/byte requires a ROM scan
        logic scan_done; // scan finished (hit or miss)
        logic reparse;   // byte must be parsed again from idle
        logic has_out;   // a result is ready
    } t_stat;

    function automatic logic [4:0] rom_len(input logic [4:0] e);
        logic [4:0] r;
        begin
            unique case (e)
                5'd0: r = 5'd3;   5'd1: r = 5'd3;   5'd2: r = 5'd4;
                5'd3: r = 5'd7;   5'd4: r = 5'd13;  5'd5: r = 5'd16;
                5'd6: r = 5'd17;  5'd7: r = 5'd19;  5'd8: r = 5'd14;
                5'd9: r = 5'd9;   5'd10: r = 5'd9;  5'd11: r = 5'd8;
                5'd12: r = 5'd12; 5'd13: r = 5'd6;  5'd14: r = 5'd4;
                5'd15: r = 5'd7;  5'd16: r = 5'd6;  5'd17: r = 5'd6;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic t_pstate rom_next(input logic [4:0] e);
        t_pstate r;
        begin
            if (e == 5'd12) r = PS_STAIP;
            else if (e == 5'd14) r = PS_IPD;
            else r = PS_WAIT_NL;
            return r;
        end
    endfunction

    function automatic logic [8*MAX_LEN-1:0] rom_text(input logic [4:0] e);
        logic [8*MAX_LEN-1:0] r;
        begin
            unique case (e)
                5'd0:  r = {"AT", 8'h0d};
                5'd1:  r = "AT+";
                5'd2:  r = {"OK", 8'h0d, 8'h0a};
                5'd3:  r = {"ERROR", 8'h0d, 8'h0a};
                5'd4:  r = {"WIFI GOT IP", 8'h0d, 8'h0a};
                5'd5:  r = {"WIFI CONNECTED", 8'h0d, 8'h0a};
                5'd6:  r = {"WIFI DISCONNECT", 8'h0d, 8'h0a};
                5'd7:  r = {"WIFI DISCONNECTED", 8'h0d, 8'h0a};
                5'd8:  r = {"DISCONNECTED", 8'h0d, 8'h0a};
                5'd9:  r = {"SEND OK", 8'h0d, 8'h0a};
                5'd10: r = {"CONNECT", 8'h0d, 8'h0a};
                5'd11: r = {"CLOSED", 8'h0d, 8'h0a};
                5'd12: r = "+CIFSR:STAIP";
                5'd13: r = "busy .";
                5'd14: r = "+IPD";
                5'd15: r = {"ready", 8'h0d, 8'h0a};
                5'd16: r = "busy p";
                5'd17: r = "busy s";
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Character at position pos, 9th bit set when none.
    function automatic logic [8:0] rom_char(input logic [4:0] e, input logic [4:0] pos);
        logic [4:0]           l;
        logic [8*MAX_LEN-1:0] t;
        logic [4:0]           sh;
        begin
            l = rom_len(e);
            t = rom_text(e);
            if (e >= 5'(RESPONSE_COUNT) || pos >= l) begin
                return 9'h100;
            end
            sh = 5'(l - pos - 5'd1);
            return {1'b0, t[8*sh +: 8]};
        end
    endfunction

endpackage

FILE: rtl/atrp_ctrl.sv
// Controller for the AT response parser: issues ticks and sequences load, step, ROM scan and
// result delivery. Depends on atrp_pkg.
module atrp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    input  logic            i_discard,
    input  logic            i_out_ready,
    output logic            o_valid,
    input  atrp_pkg::t_stat i_stat,
    output atrp_pkg::t_cmd  o_cmd
);
    atrp_pkg::t_cstate r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atrp_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            atrp_pkg::C_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op) begin
                        o_cmd.tick = 1'b1;
                    end else if (!i_discard) begin
                        o_cmd.load = 1'b1;
                        n_state    = atrp_pkg::C_EXEC;
                    end
                end
            end
            atrp_pkg::C_EXEC: begin
                if (i_stat.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = atrp_pkg::C_SCAN;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_stat.reparse) n_state = atrp_pkg::C_EXEC;
                    else if (i_stat.has_out) n_state = atrp_pkg::C_OUT;
                    else n_state = atrp_pkg::C_IDLE;
                end
            end
            atrp_pkg::C_SCAN: begin
                o_cmd.scan_next = 1'b1;
                if (i_stat.scan_done) begin
                    if (i_stat.reparse) n_state = atrp_pkg::C_EXEC;
                    else if (i_stat.has_out) n_state = atrp_pkg::C_OUT;
                    else n_state = atrp_pkg::C_IDLE;
                end
            end
            atrp_pkg::C_OUT: begin
                o_valid = 1'b1;
                if (i_out_ready) n_state = atrp_pkg::C_IDLE;
            end
            default: n_state = atrp_pkg::C_IDLE;
        endcase
    end
endmodule

FILE: rtl/atrp_dp.sv
// Datapath for the AT response parser: parse state, counters, ROM scanner
// and result register. Depends on atrp_pkg.
module atrp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic [7:0]      i_rx_byte,
    input  atrp_pkg::t_cmd  i_cmd,
    output atrp_pkg::t_stat o_stat,
    output logic [2:0]      o_event_res,
    output logic [4:0]      o_response_id,
    output logic [7:0]      o_data,
    output logic [7:0]      o_conn_id,
    output logic            o_last
);
    logic [3:0]  r_ps, n_ps;
    logic [4:0]  r_entry, n_entry;
    logic [4:0]  r_char, n_char;
    logic [15:0] r_cnt, n_cnt;
    logic [4:0]  r_ipl, n_ipl;
    logic [7:0]  r_conn, n_conn;
    logic [1:0]  r_quiet, n_quiet;
    logic        r_ws;
    logic [7:0]  r_byte;
    logic [4:0]  r_se, n_se;       // scan entry
    logic        n_out;
    logic        n_rep;
    logic [2:0]  r_ev, n_ev;
    logic [4:0]  r_rid, n_rid;
    logic [7:0]  r_dat, n_dat;
    logic [7:0]  r_oconn, n_oconn;
    logic        r_last, n_last;

    logic [8:0]  w_cur_char, w_scan_char;
    logic        w_digit;
    logic [3:0]  w_dig;
    logic [4:0]  w_len;
    logic [4:0]  w_scan_pos;

    assign w_digit     = (r_byte >= "0") && (r_byte <= "9");
    assign w_dig       = 4'(r_byte - "0");
    assign w_cur_char  = atrp_pkg::rom_char(r_entry, r_char);
    assign w_scan_pos  = (r_ps == 4'(atrp_pkg::PS_IDLE)) ? 5'd0 : r_char;
    assign w_scan_char = atrp_pkg::rom_char(r_se, w_scan_pos);
    assign w_len       = atrp_pkg::rom_len(r_se);

    always_comb begin
        o_stat.need_scan = (r_ps == 4'(atrp_pkg::PS_IDLE)) ||
                           ((r_ps == 4'(atrp_pkg::PS_MATCH)) &&
                            (w_cur_char != {1'b0, r_byte}));
        o_stat.scan_done = n_rep || n_out || (n_ps != r_ps) || (r_se != n_se) == 1'b0;
        o_stat.reparse   = n_rep;
        o_stat.has_out   = n_out;
    end

    always_comb begin
        n_ps = r_ps; n_entry = r_entry; n_char = r_char; n_cnt = r_cnt;
        n_ipl = r_ipl; n_conn = r_conn; n_quiet = r_quiet; n_se = r_se;
        n_out = 1'b0; n_rep = 1'b0;
        n_ev = r_ev; n_rid = r_rid; n_dat = r_dat; n_oconn = r_oconn; n_last = r_last;
        if (i_cmd.tick) begin
            if (r_quiet != 2'd0) begin
                n_quiet = r_quiet - 2'd1;
                if (r_quiet == 2'd1) n_ps = 4'(atrp_pkg::PS_IDLE);
            end
        end else if (i_cmd.scan_init) begin
            n_se = 5'd0;
        end else if (i_cmd.scan_next) begin
            // one ROM entry per cycle; n_se holds unless scan continues
            if (r_se >= 5'(atrp_pkg::RESPONSE_COUNT)) begin
                if (r_ps == 4'(atrp_pkg::PS_IDLE)) begin
                    n_quiet = 2'd0;
                    if (r_byte == ">") begin
                        n_out = 1'b1; n_ev = atrp_pkg::EV_PROMPT; n_rid = '0;
                        n_dat = r_byte; n_oconn = '0; n_last = 1'b0;
                    end
                end else begin
                    n_ps  = 4'(atrp_pkg::PS_IDLE);
                    n_rep = 1'b1;
                end
            end else if (w_scan_char == {1'b0, r_byte}) begin
                n_entry = r_se;
                if (r_ps == 4'(atrp_pkg::PS_IDLE)) begin
                    n_cnt  = 16'(w_len - 5'd1);
                    n_ps   = 4'(atrp_pkg::PS_MATCH);
                    n_char = 5'd1;
                end else begin
                    n_cnt = 16'(w_len - (r_char + 5'd1));
                    if (w_len == r_char + 5'd1)
                        n_ps = 4'(atrp_pkg::rom_next(r_se));
                    n_char = r_char + 5'd1;
                end
            end else begin
                n_se = r_se + 5'd1;
            end
        end else if (i_cmd.step) begin
            unique case (r_ps)
                4'(atrp_pkg::PS_MATCH): begin
                    n_cnt = r_cnt - 16'd1;
                    if (r_cnt == 16'd1 || r_byte == 8'h0d)
                        n_ps = 4'(atrp_pkg::rom_next(r_entry));
                    else n_char = r_char + 5'd1;
                end
                4'(atrp_pkg::PS_WAIT_NL): begin
                    if (r_byte == 8'h0a) begin
                        n_ps = 4'(atrp_pkg::PS_IDLE);
                        n_out = 1'b1; n_ev = atrp_pkg::EV_DONE; n_rid = r_entry;
                        n_dat = '0; n_oconn = '0; n_last = 1'b0;
                    end
                end
                4'(atrp_pkg::PS_STAIP): begin
                    if (r_byte == ",") n_ps = 4'(atrp_pkg::PS_QUOTE);
                    else begin n_ps = 4'(atrp_pkg::PS_IDLE); n_rep = 1'b1; end
                end
                4'(atrp_pkg::PS_QUOTE): begin
                    if (r_byte == 8'h22) begin
                        n_ps = 4'(atrp_pkg::PS_IP); n_ipl = '0;
                    end
                end
                4'(atrp_pkg::PS_IP): begin
                    if (r_byte == 8'h22 || r_ipl == 5'(atrp_pkg::IP_CHARS))
                        n_ps = 4'(atrp_pkg::PS_IP_NL);
                    else begin
                        n_ipl = r_ipl + 5'd1;
                        n_out = 1'b1; n_ev = atrp_pkg::EV_IP_CHAR; n_rid = '0;
                        n_dat = r_byte; n_oconn = '0; n_last = 1'b0;
                    end
                end
                4'(atrp_pkg::PS_IP_NL): begin
                    if (r_byte == 8'h0a) begin
                        n_ps = 4'(atrp_pkg::PS_IDLE);
                        n_out = 1'b1;
                        n_ev = (r_ipl < 5'(atrp_pkg::IP_CHARS)) ?
                               atrp_pkg::EV_IP_DONE : atrp_pkg::EV_IP_BAD;
                        n_rid = '0; n_dat = '0; n_oconn = '0; n_last = 1'b0;
                    end
                end
                4'(atrp_pkg::PS_IPD): begin
                    if (r_byte == ",") begin
                        if (r_ws) begin
                            n_ps = 4'(atrp_pkg::PS_CONN); n_conn = '0;
                        end else begin
                            n_ps = 4'(atrp_pkg::PS_LEN); n_cnt = '0;
                        end
                    end else begin n_ps = 4'(atrp_pkg::PS_IDLE); n_rep = 1'b1; end
                end
                4'(atrp_pkg::PS_CONN): begin
                    if (r_byte == ",") begin
                        n_ps = 4'(atrp_pkg::PS_LEN); n_cnt = '0;
                    end else if (w_digit)
                        n_conn = 8'((r_conn << 3) + (r_conn << 1) + 8'(w_dig));
                    else begin n_ps = 4'(atrp_pkg::PS_IDLE); n_rep = 1'b1; end
                end
                4'(atrp_pkg::PS_LEN): begin
                    if (r_byte == ":")
                        n_ps = (r_cnt != 16'd0) ? 4'(atrp_pkg::PS_PAYLOAD)
                                                : 4'(atrp_pkg::PS_IDLE);
                    else if (w_digit)
                        n_cnt = 16'((r_cnt << 3) + (r_cnt << 1) + 16'(w_dig));
                    else begin n_ps = 4'(atrp_pkg::PS_IDLE); n_rep = 1'b1; end
                end
                4'(atrp_pkg::PS_PAYLOAD): begin
                    n_cnt = r_cnt - 16'd1;
                    n_out = 1'b1; n_ev = atrp_pkg::EV_PAYLOAD; n_rid = '0;
                    n_dat = r_byte; n_oconn = r_conn;
                    n_last = (r_cnt == 16'd1);
                    if (r_cnt == 16'd1) n_ps = 4'(atrp_pkg::PS_IDLE);
                end
                default: begin
                    n_ps = 4'(atrp_pkg::PS_IDLE); n_quiet = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= '0; r_entry <= '0; r_char <= '0; r_cnt <= '0;
            r_ipl <= '0; r_conn <= '0; r_quiet <= '0; r_ws <= 1'b0;
            r_se <= '0;
        end else begin
            if (i_cfg_we) r_ws <= i_cfg_data;
            r_ps <= n_ps; r_entry <= n_entry; r_char <= n_char; r_cnt <= n_cnt;
            r_ipl <= n_ipl; r_conn <= n_conn; r_se <= n_se;
            r_quiet <= i_cmd.load ? 2'(atrp_pkg::QUIET_LIMIT) : n_quiet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_byte <= i_rx_byte;
        r_ev <= n_ev; r_rid <= n_rid; r_dat <= n_dat; r_oconn <= n_oconn; r_last <= n_last;
    end

    assign o_event_res   = r_ev;
    assign o_response_id = r_rid;
    assign o_data        = r_dat;
    assign o_conn_id     = r_oconn;
    assign o_last        = r_last;
endmodule

FILE: rtl/at_response_parser.sv
// AT response parser top level: controller plus datapath.
// Operation: a tick or discarded byte is handled in the idle state; a byte is
// loaded, then stepped, with a ROM scan where needed (one ROM entry per cycle),
// at most two scans per byte, and the result is held until i_ready.
// One item at a time: no new input is accepted until the last one is through.
// Reset: synchronous active-low i_rst_n returns the parser to idle.
module at_response_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    input  logic       i_discard,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_res,
    output logic [4:0] o_response_id,
    output logic [7:0] o_data,
    output logic [7:0] o_conn_id,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);
    atrp_pkg::t_cmd  w_cmd;
    atrp_pkg::t_stat w_stat;

    // Controller: accepts a transfer, then steps the datapath until done.
    atrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_discard   (i_discard),
        .i_out_ready (i_ready),
        .o_valid     (o_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: hold parse state and scan the ROM one entry per cycle.
    atrp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_event_res   (o_event_res),
        .o_response_id (o_response_id),
        .o_data        (o_data),
        .o_conn_id     (o_conn_id),
        .o_last        (o_last)
    );

`ifndef NO_ASSERTIONS
    // Never accept input while a result is presented.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("accept while result pending");
    // Event code stays in its legal range while presented.
    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_res <= atrp_pkg::EV_PROMPT)) else $error("bad event");
    // Last only on payload results.
    a_last_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_event_res == atrp_pkg::EV_PAYLOAD))
        else $error("last on non-payload");
`endif
endmodule
